FILE: hdl/gdu_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date unit.
// No dependencies; used by every stage module and the top level.

package gdu_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int ORD_W    = 9;
    localparam int WDAY_W   = 3;
    localparam int Q100_W   = 8;    // year / 100 fits in 8 bits for 14-bit years
    localparam int WSUM_W   = 15;   // Sakamoto sum before mod 7
    localparam int CFG_IDX_W = 2;

    localparam logic [YEAR_W-1:0] YEAR_LAST = 14'd9999;
    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1760;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd9999;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PROD_W = YEAR_W + DIV100_MUL_W;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 2'd1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // after stage 1: range checks and the two divisions by 100
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [YEAR_W-1:0]  yw;       // year, less one for Jan/Feb
        logic [Q100_W-1:0]  q_y;      // year / 100
        logic [Q100_W-1:0]  q_yw;     // yw / 100
        logic               month_ok;
        logic               year_ok;  // 1..9999
        logic               lim_ok;   // within min_year..max_year
    } s1_t;

    // after stage 2: leap flag and weekday sum
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               leap;
        logic [WSUM_W-1:0]  wsum;
        logic               month_ok;
        logic               year_ok;
        logic               lim_ok;
    } s2_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] prev_month;
        logic [DAY_W-1:0]   prev_day;
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_day;
        logic [WDAY_W-1:0]  weekday;
        logic [ORD_W-1:0]   ordinal_day;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Sakamoto month offsets
    function automatic logic [2:0] sak_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // days in the year before the first of month m (non-leap)
    function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [ORD_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] r;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2:                    r = leap ? 5'd29 : 5'd28;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/gregorian_date_unit_core.sv
// Gregorian date unit: day of year, weekday, next/previous date, valid flag.
// Each item passes the three register stages in order: division, leap, output;
// one item per cycle sustained while m_tready stays high.
// Throughput is set by the three register stages, each of which takes a new
// item whenever it is empty or its successor takes its item.
// Reset (aresetn low, synchronous) empties the pipeline and loads the year
// limits with 1760 and 9999. Depends on gdu_pkg and the three stage modules.

module gregorian_date_unit_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [4:0] day_in, [8:5] month_in, [22:9] year_in, [23] zero
    input  logic [23:0]                       s_tdata,

    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [8:0] ordinal_day, [11:9] weekday, [16:12] next_day, [20:17] next_month,
    // [34:21] next_year, [39:35] prev_day, [43:40] prev_month,
    // [57:44] prev_year, [63:58] zero
    output logic [63:0]                       m_tdata,
    // [0] date_ok
    output logic                              m_tuser,

    // configuration writes: index 0 min_year, index 1 max_year
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gdu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gdu_pkg::YEAR_W-1:0]        cfg_data
);

    logic [gdu_pkg::YEAR_W-1:0]  min_year_reg;
    logic [gdu_pkg::YEAR_W-1:0]  max_year_reg;

    logic              s1_valid, s1_ready;
    gdu_pkg::s1_t      s1_data;
    logic              s2_valid, s2_ready;
    gdu_pkg::s2_t      s2_data;
    gdu_pkg::result_t  res;

    // register writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_year_reg <= gdu_pkg::MIN_YEAR_RST;
            max_year_reg <= gdu_pkg::MAX_YEAR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                gdu_pkg::REG_MIN_YEAR: min_year_reg <= cfg_data;
                gdu_pkg::REG_MAX_YEAR: max_year_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: divides by 100, range and limit checks
    gdu_div_stage u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .day       (s_tdata[4:0]),
        .month     (s_tdata[8:5]),
        .year      (s_tdata[22:9]),
        .min_year  (min_year_reg),
        .max_year  (max_year_reg),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // stage 2: leap flag, weekday sum
    gdu_leap_stage u_leap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // stage 3: calendar results into the output register
    gdu_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res),
        .out_ok    (m_tuser)
    );

    assign m_tdata = {6'd0, res};

endmodule

FILE: hdl/gdu_div_stage.sv
// Stage 1: range checks, year limit compare and the two divisions by 100.
// Depends on gdu_pkg.

module gdu_div_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [gdu_pkg::DAY_W-1:0]       day,
    input  logic [gdu_pkg::MONTH_W-1:0]     month,
    input  logic [gdu_pkg::YEAR_W-1:0]      year,
    input  logic [gdu_pkg::YEAR_W-1:0]      min_year,
    input  logic [gdu_pkg::YEAR_W-1:0]      max_year,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gdu_pkg::s1_t                    out_data
);

    logic                                  valid_reg;
    gdu_pkg::s1_t                          data_reg;
    gdu_pkg::s1_t                          data_next;
    logic [gdu_pkg::YEAR_W-1:0]            yw;
    logic [gdu_pkg::DIV100_PROD_W-1:0]     prod_y;
    logic [gdu_pkg::DIV100_PROD_W-1:0]     prod_yw;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        yw      = year - ((month < gdu_pkg::MONTH_MAR) ? 14'd1 : 14'd0);
        prod_y  = gdu_pkg::DIV100_PROD_W'(year) * gdu_pkg::DIV100_PROD_W'(gdu_pkg::DIV100_MUL);
        prod_yw = gdu_pkg::DIV100_PROD_W'(yw) * gdu_pkg::DIV100_PROD_W'(gdu_pkg::DIV100_MUL);

        data_next.day      = day;
        data_next.month    = month;
        data_next.year     = year;
        data_next.yw       = yw;
        data_next.q_y      = prod_y[gdu_pkg::DIV100_SHIFT +: gdu_pkg::Q100_W];
        data_next.q_yw     = prod_yw[gdu_pkg::DIV100_SHIFT +: gdu_pkg::Q100_W];
        data_next.month_ok = (month >= gdu_pkg::MONTH_JAN) && (month <= gdu_pkg::MONTH_DEC);
        data_next.year_ok  = (year != '0) && (year <= gdu_pkg::YEAR_LAST);
        data_next.lim_ok   = (year >= min_year) && (year <= max_year);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/gdu_leap_stage.sv
// Stage 2: leap-year test from year mod 100 and the Sakamoto weekday sum.
// Depends on gdu_pkg.

module gdu_leap_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  gdu_pkg::s1_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output gdu_pkg::s2_t  out_data
);

    logic                          valid_reg;
    gdu_pkg::s2_t                  data_reg;
    gdu_pkg::s2_t                  data_next;
    logic [gdu_pkg::YEAR_W-1:0]    rem100;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rem100 = in_data.year - gdu_pkg::YEAR_W'(in_data.q_y) * 14'd100;

        data_next.day      = in_data.day;
        data_next.month    = in_data.month;
        data_next.year     = in_data.year;
        // divisible by 4, and either not by 100 or also by 400
        data_next.leap     = (in_data.year[1:0] == 2'd0) &&
                             ((rem100 != '0) || (in_data.q_y[1:0] == 2'd0));
        data_next.wsum     = gdu_pkg::WSUM_W'(in_data.yw)
                           + gdu_pkg::WSUM_W'(in_data.yw[gdu_pkg::YEAR_W-1:2])
                           - gdu_pkg::WSUM_W'(in_data.q_yw)
                           + gdu_pkg::WSUM_W'(in_data.q_yw[gdu_pkg::Q100_W-1:2])
                           + gdu_pkg::WSUM_W'(gdu_pkg::sak_offset(in_data.month))
                           + gdu_pkg::WSUM_W'(in_data.day);
        data_next.month_ok = in_data.month_ok;
        data_next.year_ok  = in_data.year_ok;
        data_next.lim_ok   = in_data.lim_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/gdu_out_stage.sv
// Stage 3: month length, day check, ordinal day, neighbor dates, weekday mod 7.
// Holds the output register. Depends on gdu_pkg.

module gdu_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdu_pkg::s2_t      in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output gdu_pkg::result_t  out_data,
    output logic              out_ok
);

    logic                           valid_reg;
    gdu_pkg::result_t               data_reg;
    gdu_pkg::result_t               data_next;
    logic                           ok_reg;
    logic                           ok_next;
    logic                           form_ok;
    logic [gdu_pkg::DAY_W-1:0]      len;
    logic [gdu_pkg::MONTH_W-1:0]    m;
    logic [gdu_pkg::DAY_W-1:0]      d;
    logic [gdu_pkg::YEAR_W-1:0]     y;
    logic [5:0]                     fold1;
    logic [3:0]                     fold2;
    gdu_pkg::result_t               res;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        m   = in_data.month;
        d   = in_data.day;
        y   = in_data.year;
        len = gdu_pkg::month_len(m, in_data.leap);
        form_ok = in_data.month_ok && in_data.year_ok && (d != '0) && (d <= len);

        // mod 7 by folding octal digits (8 == 1 mod 7)
        fold1 = 6'(in_data.wsum[14:12]) + 6'(in_data.wsum[11:9]) + 6'(in_data.wsum[8:6])
              + 6'(in_data.wsum[5:3]) + 6'(in_data.wsum[2:0]);
        fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
        res.weekday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

        res.ordinal_day = gdu_pkg::days_before(m) + gdu_pkg::ORD_W'(d)
                        + (((m > gdu_pkg::MONTH_FEB) && in_data.leap) ? 9'd1 : 9'd0);

        if (d < len) begin
            res.next_day   = d + 5'd1;
            res.next_month = m;
            res.next_year  = y;
        end else if (m < gdu_pkg::MONTH_DEC) begin
            res.next_day   = 5'd1;
            res.next_month = m + 4'd1;
            res.next_year  = y;
        end else begin
            res.next_day   = 5'd1;
            res.next_month = gdu_pkg::MONTH_JAN;
            res.next_year  = y + 14'd1;
        end

        if (d > 5'd1) begin
            res.prev_day   = d - 5'd1;
            res.prev_month = m;
            res.prev_year  = y;
        end else if (m > gdu_pkg::MONTH_JAN) begin
            res.prev_day   = gdu_pkg::month_len(m - 4'd1, in_data.leap);
            res.prev_month = m - 4'd1;
            res.prev_year  = y;
        end else begin
            res.prev_day   = 5'd31;
            res.prev_month = gdu_pkg::MONTH_DEC;
            res.prev_year  = y - 14'd1;
        end

        // malformed dates give all-zero fields
        data_next = form_ok ? res : '0;
        ok_next   = form_ok && in_data.lim_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
            ok_reg   <= ok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_ok    = ok_reg;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

// Testbench for gregorian_date_unit_core: directed and random dates checked against a
// calendar predictor kept in the bench, with random source gaps and sink stalls.
// Depends on gdu_pkg and the date unit RTL.

module tb;

    localparam int LATENCY        = 3;
    localparam int WATCHDOG_LIMIT = 2000;

    // indexes the unit does not decode; writes to them must leave the limits alone
    localparam logic [gdu_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [gdu_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // input item, day in the low bits as on s_tdata
    typedef struct packed {
        logic [gdu_pkg::YEAR_W-1:0]  year;
        logic [gdu_pkg::MONTH_W-1:0] month;
        logic [gdu_pkg::DAY_W-1:0]   day;
    } date_t;

    typedef struct {
        gdu_pkg::result_t cal;
        logic             ok;
    } date_info_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [63:0]                   m_tdata;
    logic                          m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [gdu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gdu_pkg::YEAR_W-1:0]    cfg_data  = '0;

    date_t      date_q[$];          // dates waiting to be driven
    date_info_t expected_q[$];      // predicted results, oldest first
    date_t      held_date;
    logic [gdu_pkg::YEAR_W-1:0] year_lo = gdu_pkg::MIN_YEAR_RST;
    logic [gdu_pkg::YEAR_W-1:0] year_hi = gdu_pkg::MAX_YEAR_RST;
    int unsigned src_gap_max  = 0;
    int unsigned sink_gap_max = 0;
    int unsigned src_wait     = 0;
    int unsigned sink_wait    = 0;
    int unsigned error_count  = 0;
    int unsigned result_count = 0;
    int unsigned stuck_cycles = 0;

    gregorian_date_unit_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            4, 6, 9, 11:        return 30;
            gdu_pkg::MONTH_FEB: return is_leap(y) ? 29 : 28;
            default:            return 31;
        endcase
    endfunction

    // days in a common year before the first of month m
    function automatic int unsigned days_ahead(input int unsigned m);
        int unsigned acc;
        acc = 0;
        for (int unsigned k = 1; k < m; k++)
            acc += month_days(k, 1);
        return acc;
    endfunction

    function automatic date_info_t predict_date(input date_t d,
                                                input logic [gdu_pkg::YEAR_W-1:0] lo,
                                                input logic [gdu_pkg::YEAR_W-1:0] hi);
        date_info_t  r;
        int unsigned dd, mm, yy, len, yw, pm;
        r.cal = '0;
        r.ok  = 1'b0;
        dd = 32'(d.day);
        mm = 32'(d.month);
        yy = 32'(d.year);
        // malformed dates give all zeros
        if (mm < 1 || mm > 12 || yy < 1 || yy > gdu_pkg::YEAR_LAST)
            return r;
        len = month_days(mm, yy);
        if (dd < 1 || dd > len)
            return r;

        r.cal.ordinal_day = gdu_pkg::ORD_W'(days_ahead(mm) + dd
                            + ((mm > gdu_pkg::MONTH_FEB && is_leap(yy)) ? 1 : 0));
        // Sakamoto: Jan/Feb count in the previous year; the month offset is the
        // common-year day count before the month, one less from March on, mod 7
        yw = (mm < gdu_pkg::MONTH_MAR) ? yy - 1 : yy;
        r.cal.weekday = gdu_pkg::WDAY_W'((yw + yw / 4 - yw / 100 + yw / 400 + days_ahead(mm)
                                 - ((mm > gdu_pkg::MONTH_FEB) ? 1 : 0) + dd) % 7);

        if (dd < len) begin
            r.cal.next_day   = gdu_pkg::DAY_W'(dd + 1);
            r.cal.next_month = gdu_pkg::MONTH_W'(mm);
            r.cal.next_year  = gdu_pkg::YEAR_W'(yy);
        end else if (mm < gdu_pkg::MONTH_DEC) begin
            r.cal.next_day   = gdu_pkg::DAY_W'(1);
            r.cal.next_month = gdu_pkg::MONTH_W'(mm + 1);
            r.cal.next_year  = gdu_pkg::YEAR_W'(yy);
        end else begin
            r.cal.next_day   = gdu_pkg::DAY_W'(1);
            r.cal.next_month = gdu_pkg::MONTH_JAN;
            r.cal.next_year  = gdu_pkg::YEAR_W'(yy + 1);
        end

        if (dd > 1) begin
            r.cal.prev_day   = gdu_pkg::DAY_W'(dd - 1);
            r.cal.prev_month = gdu_pkg::MONTH_W'(mm);
            r.cal.prev_year  = gdu_pkg::YEAR_W'(yy);
        end else if (mm > gdu_pkg::MONTH_JAN) begin
            pm = mm - 1;
            r.cal.prev_day   = gdu_pkg::DAY_W'(month_days(pm, yy));
            r.cal.prev_month = gdu_pkg::MONTH_W'(pm);
            r.cal.prev_year  = gdu_pkg::YEAR_W'(yy);
        end else begin
            r.cal.prev_day   = gdu_pkg::DAY_W'(31);
            r.cal.prev_month = gdu_pkg::MONTH_DEC;
            r.cal.prev_year  = gdu_pkg::YEAR_W'(yy - 1);
        end

        r.ok = (yy >= lo) && (yy <= hi);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic date_t date_of(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
        date_t r;
        r.day   = gdu_pkg::DAY_W'(d);
        r.month = gdu_pkg::MONTH_W'(m);
        r.year  = gdu_pkg::YEAR_W'(y);
        return r;
    endfunction

    // mostly well-formed dates near month, year and limit edges; some raw noise
    function automatic date_t random_date(input logic [gdu_pkg::YEAR_W-1:0] lo,
                                          input logic [gdu_pkg::YEAR_W-1:0] hi);
        date_t       r;
        int unsigned y, m, len;
        if ($urandom_range(0, 99) < 15) begin
            r.day   = gdu_pkg::DAY_W'($urandom);
            r.month = gdu_pkg::MONTH_W'($urandom);
            r.year  = gdu_pkg::YEAR_W'($urandom);
            return r;
        end
        case ($urandom_range(0, 7))
            0:       y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
            1:       y = lo + $urandom_range(0, 2) - 1;
            2:       y = hi + $urandom_range(0, 2) - 1;
            3:       y = 100 * $urandom_range(1, 99);
            4:       y = 4 * $urandom_range(1, 2499);
            default: y = $urandom_range(1, 9999);
        endcase
        y = y & 14'h3FFF;
        if ($urandom_range(0, 3) == 0)
            m = $urandom_range(0, 1) ? 32'(gdu_pkg::MONTH_FEB) : 32'(gdu_pkg::MONTH_DEC);
        else
            m = $urandom_range(1, 12);
        len = month_days(m, y);
        case ($urandom_range(0, 5))
            0:       r.day = gdu_pkg::DAY_W'(len);
            1:       r.day = gdu_pkg::DAY_W'(1);
            2:       r.day = gdu_pkg::DAY_W'(len + 1);     // one past the month end
            default: r.day = gdu_pkg::DAY_W'($urandom_range(1, len));
        endcase
        r.month = gdu_pkg::MONTH_W'(m);
        r.year  = gdu_pkg::YEAR_W'(y);
        return r;
    endfunction

    task automatic add_random(input int unsigned n);
        repeat (n) date_q.push_back(random_date(year_lo, year_hi));
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (date_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    endtask

    task automatic write_limit(input logic [gdu_pkg::CFG_IDX_W-1:0] idx,
                               input logic [gdu_pkg::YEAR_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == gdu_pkg::REG_MIN_YEAR)
            year_lo = val;
        else if (idx == gdu_pkg::REG_MAX_YEAR)
            year_hi = val;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [gdu_pkg::YEAR_W-1:0] lo,
                             input logic [gdu_pkg::YEAR_W-1:0] hi,
                             input int unsigned src_max, input int unsigned sink_max,
                             input int unsigned n);
        write_limit(gdu_pkg::REG_MIN_YEAR, lo);
        write_limit(gdu_pkg::REG_MAX_YEAR, hi);
        src_gap_max  = src_max;
        sink_gap_max = sink_max;
        add_random(n);
        wait_drained();
    endtask

    task automatic log_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            log_error($sformatf("result %0d: %s is %0d, expected %0d",
                                result_count, name, got, want));
    endtask

    // ---------------- driver ----------------
    // Predicts on accept, then loads the next date after its drawn gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_date(held_date, year_lo, year_hi));
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (date_q.size() > 0) begin
                    held_date = date_q.pop_front();
                    s_tdata  <= {1'b0, held_date};
                    s_tvalid <= 1'b1;
                    src_wait = $urandom_range(0, src_gap_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin : monitor
        date_info_t       want;
        gdu_pkg::result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    log_error($sformatf("result %0d arrived with nothing expected", result_count));
                end else begin
                    want = expected_q.pop_front();
                    got  = m_tdata[gdu_pkg::RESULT_W-1:0];
                    check_field("ordinal_day", 16'(got.ordinal_day), 16'(want.cal.ordinal_day));
                    check_field("weekday",     16'(got.weekday),     16'(want.cal.weekday));
                    check_field("next_day",    16'(got.next_day),    16'(want.cal.next_day));
                    check_field("next_month",  16'(got.next_month),  16'(want.cal.next_month));
                    check_field("next_year",   16'(got.next_year),   16'(want.cal.next_year));
                    check_field("prev_day",    16'(got.prev_day),    16'(want.cal.prev_day));
                    check_field("prev_month",  16'(got.prev_month),  16'(want.cal.prev_month));
                    check_field("prev_year",   16'(got.prev_year),   16'(want.cal.prev_year));
                    check_field("date_ok",     16'(m_tuser),         16'(want.ok));
                end
                result_count++;
                sink_wait = $urandom_range(0, sink_gap_max);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed dates under the reset limits 1760..9999
        src_gap_max  = 15;
        sink_gap_max = 15;
        date_q.push_back(date_of(1, 1, 1));         // previous year is 0
        date_q.push_back(date_of(31, 12, 9999));    // next year is 10000
        date_q.push_back(date_of(29, 2, 2000));     // leap by 400
        date_q.push_back(date_of(29, 2, 1900));     // not leap by 100: malformed
        date_q.push_back(date_of(28, 2, 1900));
        date_q.push_back(date_of(29, 2, 2024));
        date_q.push_back(date_of(1, 3, 2024));      // back to Feb 29
        date_q.push_back(date_of(1, 3, 2023));      // back to Feb 28
        date_q.push_back(date_of(31, 8, 2023));     // August has 31 days
        date_q.push_back(date_of(31, 4, 2023));     // April 31 malformed
        date_q.push_back(date_of(30, 4, 2023));
        date_q.push_back(date_of(0, 1, 2000));      // day zero
        date_q.push_back(date_of(31, 15, 16383));   // all field bits set
        date_q.push_back(date_of(1, 0, 2000));      // month zero
        date_q.push_back(date_of(1, 13, 2000));
        date_q.push_back(date_of(1, 1, 0));         // year zero
        date_q.push_back(date_of(1, 1, 10000));     // year past 9999
        date_q.push_back(date_of(31, 12, 1759));    // well formed, below the limit
        date_q.push_back(date_of(1, 1, 1760));
        date_q.push_back(date_of(15, 6, 2020));
        date_q.push_back(date_of(31, 1, 2000));
        date_q.push_back(date_of(1, 1, 2000));
        date_q.push_back(date_of(31, 12, 1999));
        date_q.push_back(date_of(31, 12, 2000));    // ordinal 366
        date_q.push_back(date_of(30, 11, 1));
        wait_drained();

        run_phase(14'd1, 14'd9999, 0, 0, 250);      // widest legal limits, no idling
        run_phase(14'd2000, 14'd2100, 15, 15, 250);
        // pause the sender until everything is back, then carry on as before
        add_random(100);
        wait_drained();
        run_phase(14'd5000, 14'd4000, 3, 15, 250);  // crossed limits
        run_phase(14'd0, 14'h3FFF, 15, 0, 125);     // limits beyond the legal range
        write_limit(REG_SPARE_2, 14'd3000);
        write_limit(REG_SPARE_3, 14'h3FFF);
        add_random(125);
        wait_drained();
        run_phase(14'd2024, 14'd2024, 0, 15, 200);  // a single valid year
        run_phase(14'd9999, 14'd1, 15, 3, 200);
        run_phase(gdu_pkg::MIN_YEAR_RST, gdu_pkg::MAX_YEAR_RST, 7, 7, 325);

        repeat (4 * LATENCY) @(posedge aclk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
